// File: rtl/core/two_axis_pid_with_clamps_macros.svh
// Assertion macros for the two-axis PID controller.
// Included by the top level only; relies on clk and rst_n in the including scope.
`ifndef TWO_AXIS_PID_WITH_CLAMPS_MACROS_SVH
`define TWO_AXIS_PID_WITH_CLAMPS_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TAPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TAPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/tapc_pkg.sv
// Shared types and constants of the two-axis PID controller.
// No dependencies; used by the channel interfaces and the top level.
package tapc_pkg;

  // Field widths fixed by the item and register formats.
  localparam int ANGLE_W = 16;
  localparam int GAIN_W  = 16;
  localparam int DRIVE_W = 12;
  localparam int ERR_W   = 17;
  localparam int DERR_W  = 18;
  localparam int ISUM_W  = 13;
  localparam int CFG_IDX_W = 3;

  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic signed [GAIN_W-1:0]  gain_t;
  typedef logic signed [DRIVE_W-1:0] drive_t;
  typedef logic signed [ERR_W-1:0]   err_t;
  typedef logic signed [DERR_W-1:0]  derr_t;
  typedef logic signed [ISUM_W-1:0]  isum_t;
  typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;

  // Product and accumulator widths (exact, with 8 fraction bits).
  typedef logic signed [GAIN_W+ERR_W-1:0]  prod_p_t;
  typedef logic signed [GAIN_W+ISUM_W-1:0] prod_i_t;
  typedef logic signed [GAIN_W+DERR_W-1:0] prod_d_t;
  typedef logic signed [35:0]              acc_t;
  typedef logic signed [27:0]              quot_t;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOWER_PROP  = 3'd0,
    REG_LOWER_INTEG = 3'd1,
    REG_LOWER_DERIV = 3'd2,
    REG_UPPER_PROP  = 3'd3,
    REG_UPPER_INTEG = 3'd4,
    REG_UPPER_DERIV = 3'd5
  } cfg_reg_t;

  // Axis codes.
  localparam logic AXIS_LOWER = 1'b0;
  localparam logic AXIS_UPPER = 1'b1;

  // Gain set of one axis.
  typedef struct packed {
    gain_t kp;
    gain_t ki;
    gain_t kd;
  } gains_t;

  // Reset gains: proportional 2.0 in Q7.8, the others zero.
  localparam gain_t PROP_GAIN_RST = 16'sd512;
  localparam gain_t ZERO_GAIN     = 16'sd0;

  // Bias added before the arithmetic shift so that it truncates toward zero.
  localparam acc_t TRUNC_BIAS = 36'sd255;
  localparam int   FRAC_W     = 8;

endpackage

// File: rtl/core/tapc_if.sv
// Channel interfaces of the two-axis PID controller: input, result and configuration.
// Depends on tapc_pkg for the field types.

// Input item channel.
interface tapc_in_if;
  import tapc_pkg::*;
  logic   valid;
  logic   ready;
  logic   axis_select;
  angle_t measured_angle;
  angle_t target_angle;

  modport source (output valid, output axis_select, output measured_angle,
                  output target_angle, input ready);
  modport sink   (input valid, input axis_select, input measured_angle,
                  input target_angle, output ready);
endinterface

// Result item channel.
interface tapc_out_if;
  import tapc_pkg::*;
  logic   valid;
  logic   ready;
  drive_t drive_value;

  modport source (output valid, output drive_value, input ready);
  modport sink   (input valid, input drive_value, output ready);
endinterface

// Configuration write channel.
interface tapc_cfg_if;
  import tapc_pkg::*;
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  gain_t    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/two_axis_pid_with_clamps.sv
// Top level of the two-axis PID controller with integral clamp and output saturation.
// Depends on tapc_pkg, the interfaces in tapc_if.sv and two_axis_pid_with_clamps_macros.svh.
//
//   Channel   Direction  Transfer fields
//   in_chan   sink       axis_select, measured_angle, target_angle
//   out_chan  source     drive_value
//   cfg_bus   sink       index, data (always ready)
//
// One item per cycle sustained while out_chan is ready; each item passes through the input
// register, then the error/integral, product and output registers.
// The per-axis integral and previous error update as an item leaves the input
// register, so consecutive items on the same axis see each other's state.
// Each stage holds only while the stage after it is full and stalled, so bubbles
// are squeezed out and input transfers continue while a result waits.
// Reset is synchronous: pipeline valids and per-axis state clear, gains reload.
module two_axis_pid_with_clamps #(
  parameter int LOWER_INTEG_LIMIT = 3000,
  parameter int LOWER_OUT_LIMIT   = 2000,
  parameter int UPPER_INTEG_LIMIT = 800,
  parameter int UPPER_OUT_LIMIT   = 400
) (
  input  logic       clk,
  input  logic       rst_n,
  tapc_in_if.sink    in_chan,
  tapc_out_if.source out_chan,
  tapc_cfg_if.sink   cfg_bus
);
  import tapc_pkg::*;

  `include "two_axis_pid_with_clamps_macros.svh"

  // Limits in the widths of the values they bound.
  localparam derr_t LO_ILIM = derr_t'(LOWER_INTEG_LIMIT);
  localparam derr_t UP_ILIM = derr_t'(UPPER_INTEG_LIMIT);
  localparam quot_t LO_OLIM = quot_t'(LOWER_OUT_LIMIT);
  localparam quot_t UP_OLIM = quot_t'(UPPER_OUT_LIMIT);

  // Gains and per-axis state.
  gains_t gains_r [2];
  isum_t  isum_r  [2];
  err_t   perr_r  [2];

  // Stage registers.
  logic   v0_r, v1_r, v2_r, out_valid_r;
  logic   p0_axis_r;
  angle_t p0_meas_r, p0_targ_r;
  logic   s1_axis_r;
  err_t   s1_err_r;
  isum_t  s1_isum_r;
  derr_t  s1_derr_r;
  gains_t s1_gains_r;
  logic   s2_axis_r;
  prod_p_t s2_pp_r;
  prod_i_t s2_pi_r;
  prod_d_t s2_pd_r;
  drive_t out_drive_r;

  // Stage readiness, back to front.
  logic rdy1, rdy2, rdy3;
  logic t1;

  assign rdy3 = !out_valid_r || out_chan.ready;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_chan.ready = !v0_r || rdy1;
  assign t1 = v0_r && rdy1;

  assign cfg_bus.ready = 1'b1;
  assign out_chan.valid = out_valid_r;
  assign out_chan.drive_value = out_drive_r;

  // Error, clamped integral and derivative of the item in the input register.
  err_t   err_nxt;
  derr_t  sum_wide;
  derr_t  ilim;
  isum_t  isum_nxt;
  derr_t  derr_nxt;

  always_comb begin
    err_nxt  = err_t'(p0_meas_r) - err_t'(p0_targ_r);
    sum_wide = derr_t'(isum_r[p0_axis_r]) + derr_t'(err_nxt);
    ilim     = (p0_axis_r == AXIS_UPPER) ? UP_ILIM : LO_ILIM;
    if (sum_wide > ilim) begin
      isum_nxt = isum_t'(ilim);
    end else if (sum_wide < -ilim) begin
      isum_nxt = isum_t'(-ilim);
    end else begin
      isum_nxt = isum_t'(sum_wide);
    end
    derr_nxt = derr_t'(err_nxt) - derr_t'(perr_r[p0_axis_r]);
  end

  // Three independent products.
  prod_p_t pp_nxt;
  prod_i_t pi_nxt;
  prod_d_t pd_nxt;

  always_comb begin
    pp_nxt = prod_p_t'(s1_gains_r.kp) * prod_p_t'(s1_err_r);
    pi_nxt = prod_i_t'(s1_gains_r.ki) * prod_i_t'(s1_isum_r);
    pd_nxt = prod_d_t'(s1_gains_r.kd) * prod_d_t'(s1_derr_r);
  end

  // Sum, divide by 256 toward zero, saturate to the axis output limit.
  acc_t   acc;
  acc_t   acc_adj;
  quot_t  quot;
  quot_t  olim;
  quot_t  sat;
  drive_t drive_nxt;

  always_comb begin
    acc     = acc_t'(s2_pp_r) + acc_t'(s2_pi_r) + acc_t'(s2_pd_r);
    acc_adj = acc + (acc[35] ? TRUNC_BIAS : '0);
    quot    = acc_adj[35:FRAC_W];
    olim    = (s2_axis_r == AXIS_UPPER) ? UP_OLIM : LO_OLIM;
    if (quot > olim) begin
      sat = olim;
    end else if (quot < -olim) begin
      sat = -olim;
    end else begin
      sat = quot;
    end
    drive_nxt = sat[DRIVE_W-1:0];
  end

  // Control state: valids, gains and per-axis state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
      gains_r[0]  <= '{kp: PROP_GAIN_RST, ki: ZERO_GAIN, kd: ZERO_GAIN};
      gains_r[1]  <= '{kp: PROP_GAIN_RST, ki: ZERO_GAIN, kd: ZERO_GAIN};
      isum_r[0]   <= '0;
      isum_r[1]   <= '0;
      perr_r[0]   <= '0;
      perr_r[1]   <= '0;
    end else begin
      if (in_chan.ready) v0_r <= in_chan.valid;
      if (rdy1) v1_r <= v0_r;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) out_valid_r <= v2_r;

      // State moves with the item leaving the input register.
      if (t1) begin
        isum_r[p0_axis_r] <= isum_nxt;
        perr_r[p0_axis_r] <= err_nxt;
      end

      // Configuration writes; unknown indexes are dropped.
      if (cfg_bus.valid) begin
        unique case (cfg_bus.index)
          REG_LOWER_PROP:  gains_r[0].kp <= cfg_bus.data;
          REG_LOWER_INTEG: gains_r[0].ki <= cfg_bus.data;
          REG_LOWER_DERIV: gains_r[0].kd <= cfg_bus.data;
          REG_UPPER_PROP:  gains_r[1].kp <= cfg_bus.data;
          REG_UPPER_INTEG: gains_r[1].ki <= cfg_bus.data;
          REG_UPPER_DERIV: gains_r[1].kd <= cfg_bus.data;
          default: ;
        endcase
      end
    end
  end

  // Payload registers, loaded whenever their stage may advance.
  always_ff @(posedge clk) begin
    if (in_chan.ready) begin
      p0_axis_r <= in_chan.axis_select;
      p0_meas_r <= in_chan.measured_angle;
      p0_targ_r <= in_chan.target_angle;
    end
    if (rdy1) begin
      s1_axis_r  <= p0_axis_r;
      s1_err_r   <= err_nxt;
      s1_isum_r  <= isum_nxt;
      s1_derr_r  <= derr_nxt;
      s1_gains_r <= gains_r[p0_axis_r];
    end
    if (rdy2) begin
      s2_axis_r <= s1_axis_r;
      s2_pp_r   <= pp_nxt;
      s2_pi_r   <= pi_nxt;
      s2_pd_r   <= pd_nxt;
    end
    if (rdy3) begin
      out_drive_r <= drive_nxt;
    end
  end

  // Per-axis state changes only when an item leaves the input register.
  `TAPC_ASSERT_NEXT(a_state_hold, !t1, $stable(isum_r[0]) && $stable(isum_r[1]) && $stable(perr_r[0]) && $stable(perr_r[1]), "axis state changed without an item")

  // The integral handed to the multiply stage respects its axis clamp.
  `TAPC_ASSERT_NEXT(a_isum_bound, t1, (derr_t'(s1_isum_r) <= ((s1_axis_r == AXIS_UPPER) ? UP_ILIM : LO_ILIM)) && (derr_t'(s1_isum_r) >= -((s1_axis_r == AXIS_UPPER) ? UP_ILIM : LO_ILIM)), "integral outside clamp")

  // A result appears only after the multiply stage held an item.
  `TAPC_ASSERT_NOW(a_out_origin, $rose(out_valid_r), $past(v2_r), "result without a source item")

endmodule

// File: tb/tb_two_axis_pid_with_clamps.sv
// Self-checking testbench for the two-axis PID controller with integral and output clamps.
// Depends on tapc_pkg, the channel interfaces in tapc_if.sv and the top level
// two_axis_pid_with_clamps; it predicts every drive value and compares it with the block.
module tb_two_axis_pid_with_clamps;
  timeunit 1ns;
  timeprecision 1ps;
  import tapc_pkg::*;

  // Loop limits, matching the parameters given to the block.
  localparam int LOWER_ISUM_LIM = 3000;
  localparam int LOWER_DRV_LIM  = 2000;
  localparam int UPPER_ISUM_LIM = 800;
  localparam int UPPER_DRV_LIM  = 400;

  // Run shape.
  localparam int RAND_PHASES    = 8;
  localparam int ITEMS_PER_PH   = 250;
  localparam int DRAIN_SLACK    = 6;
  localparam int LONG_HOLD      = 200;
  localparam int HOLD_AFTER     = 300;
  localparam int WATCHDOG_LIMIT = 2000;

  // Field extremes.
  localparam angle_t ANGLE_MAX = 16'sh7fff;
  localparam angle_t ANGLE_MIN = 16'sh8000;
  localparam gain_t  GAIN_MAX  = 16'sh7fff;
  localparam gain_t  GAIN_MIN  = 16'sh8000;
  localparam gain_t  GAIN_ONE  = 16'sd256;

  // Register indexes past the end of the register file; writes to them are dropped.
  localparam cfg_idx_t IDX_SPARE_A = 3'd6;
  localparam cfg_idx_t IDX_SPARE_B = 3'd7;

  // Directed stimulus: either a register write or an input item. On item rows the
  // index and data columns are unused; a drive value is given only where it is obvious.
  typedef struct packed {
    bit       is_cfg;
    cfg_idx_t idx;
    gain_t    data;
    logic     axis;
    angle_t   meas;
    angle_t   targ;
    bit       has_exp;
    drive_t   exp_drive;
  } dir_row_t;

  localparam int DIR_ROWS = 34;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    // Reset gains: drive is twice the error, saturated per axis.
    '{1'b0, REG_LOWER_PROP, 16'sd0, AXIS_LOWER, 16'sd0, 16'sd0, 1'b1, 12'sd0},
    '{1'b0, REG_LOWER_PROP, 16'sd0, AXIS_LOWER, 16'sd100, 16'sd0, 1'b1, 12'sd200},
    '{1'b0, REG_LOWER_PROP, 16'sd0, AXIS_LOWER, ANGLE_MAX, ANGLE_MIN, 1'b1, 12'sd2000},
    '{1'b0, REG_LOWER_PROP, 16'sd0, AXIS_LOWER, ANGLE_MIN, ANGLE_MAX, 1'b1, -12'sd2000},
    '{1'b0, REG_LOWER_PROP, 16'sd0, AXIS_UPPER, ANGLE_MAX, ANGLE_MIN, 1'b1, 12'sd400},
    '{1'b0, REG_LOWER_PROP, 16'sd0, AXIS_UPPER, ANGLE_MIN, ANGLE_MAX, 1'b1, -12'sd400},
    '{1'b0, REG_LOWER_PROP, 16'sd0, AXIS_UPPER, -16'sd1, 16'sd0, 1'b1, -12'sd2},
    // Smallest proportional gain: the shift truncates toward zero on both signs.
    '{1'b1, REG_LOWER_PROP, 16'sd1, AXIS_LOWER, 16'sd0, 16'sd0, 1'b0, 12'sd0},
    '{1'b0, REG_LOWER_PROP, 16'sd0, AXIS_LOWER, -16'sd300, 16'sd0, 1'b1, -12'sd1},
    '{1'b0, REG_LOWER_PROP, 16'sd0, AXIS_LOWER, 16'sd300, 16'sd0, 1'b1, 12'sd1},
    // Integral only: the sum runs into its clamp in both directions.
    '{1'b1, REG_LOWER_PROP, 16'sd0, AXIS_LOWER, 16'sd0, 16'sd0, 1'b0, 12'sd0},
    '{1'b1, REG_LOWER_INTEG, GAIN_ONE, AXIS_LOWER, 16'sd0, 16'sd0, 1'b0, 12'sd0},
    '{1'b0, REG_LOWER_PROP, 16'sd0, AXIS_LOWER, ANGLE_MAX, ANGLE_MIN, 1'b0, 12'sd0},
    '{1'b0, REG_LOWER_PROP, 16'sd0, AXIS_LOWER, ANGLE_MIN, ANGLE_MAX, 1'b0, 12'sd0},
    '{1'b0, REG_LOWER_PROP, 16'sd0, AXIS_LOWER, 16'sd0, 16'sd0, 1'b0, 12'sd0},
    // Derivative only, at both gain extremes.
    '{1'b1, REG_LOWER_INTEG, 16'sd0, AXIS_LOWER, 16'sd0, 16'sd0, 1'b0, 12'sd0},
    '{1'b1, REG_LOWER_DERIV, GAIN_MAX, AXIS_LOWER, 16'sd0, 16'sd0, 1'b0, 12'sd0},
    '{1'b0, REG_LOWER_PROP, 16'sd0, AXIS_LOWER, 16'sd1000, 16'sd0, 1'b0, 12'sd0},
    '{1'b0, REG_LOWER_PROP, 16'sd0, AXIS_LOWER, -16'sd1000, 16'sd0, 1'b0, 12'sd0},
    '{1'b1, REG_LOWER_DERIV, GAIN_MIN, AXIS_LOWER, 16'sd0, 16'sd0, 1'b0, 12'sd0},
    '{1'b0, REG_LOWER_PROP, 16'sd0, AXIS_LOWER, ANGLE_MAX, ANGLE_MIN, 1'b0, 12'sd0},
    // Upper axis with all three terms; the lower axis state must not move.
    '{1'b1, REG_UPPER_PROP, GAIN_MAX, AXIS_LOWER, 16'sd0, 16'sd0, 1'b0, 12'sd0},
    '{1'b1, REG_UPPER_INTEG, GAIN_MIN, AXIS_LOWER, 16'sd0, 16'sd0, 1'b0, 12'sd0},
    '{1'b1, REG_UPPER_DERIV, GAIN_ONE, AXIS_LOWER, 16'sd0, 16'sd0, 1'b0, 12'sd0},
    '{1'b0, REG_LOWER_PROP, 16'sd0, AXIS_UPPER, 16'sd500, 16'sd0, 1'b0, 12'sd0},
    '{1'b0, REG_LOWER_PROP, 16'sd0, AXIS_UPPER, ANGLE_MIN, ANGLE_MAX, 1'b0, 12'sd0},
    '{1'b0, REG_LOWER_PROP, 16'sd0, AXIS_UPPER, 16'sd5, 16'sd6, 1'b0, 12'sd0},
    // Writes past the register file are dropped.
    '{1'b1, IDX_SPARE_A, GAIN_MAX, AXIS_LOWER, 16'sd0, 16'sd0, 1'b0, 12'sd0},
    '{1'b1, IDX_SPARE_B, GAIN_MIN, AXIS_LOWER, 16'sd0, 16'sd0, 1'b0, 12'sd0},
    '{1'b0, REG_LOWER_PROP, 16'sd0, AXIS_UPPER, 16'sd1, 16'sd0, 1'b0, 12'sd0},
    // Most negative proportional gain alone on the upper axis.
    '{1'b1, REG_UPPER_PROP, GAIN_MIN, AXIS_LOWER, 16'sd0, 16'sd0, 1'b0, 12'sd0},
    '{1'b1, REG_UPPER_INTEG, 16'sd0, AXIS_LOWER, 16'sd0, 16'sd0, 1'b0, 12'sd0},
    '{1'b1, REG_UPPER_DERIV, 16'sd0, AXIS_LOWER, 16'sd0, 16'sd0, 1'b0, 12'sd0},
    '{1'b0, REG_LOWER_PROP, 16'sd0, AXIS_UPPER, 16'sd3, 16'sd0, 1'b1, -12'sd384}
  };

  localparam angle_t ANGLE_CORNERS [4] = '{ANGLE_MAX, ANGLE_MIN, 16'sd0, -16'sd1};

  logic clk;
  logic rst_n;

  tapc_in_if  in_chan ();
  tapc_out_if out_chan ();
  tapc_cfg_if cfg_bus ();

  two_axis_pid_with_clamps #(
    .LOWER_INTEG_LIMIT(LOWER_ISUM_LIM),
    .LOWER_OUT_LIMIT  (LOWER_DRV_LIM),
    .UPPER_INTEG_LIMIT(UPPER_ISUM_LIM),
    .UPPER_OUT_LIMIT  (UPPER_DRV_LIM)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan),
    .cfg_bus (cfg_bus)
  );

  // Predictor copy of the gains and the per-axis loop state.
  gain_t  kp_gain [2];
  gain_t  ki_gain [2];
  gain_t  kd_gain [2];
  isum_t  integ_acc [2];
  err_t   prev_error [2];

  drive_t drive_expected_q [$];

  int  error_count;
  int  items_sent;
  int  results_checked;
  int  cfg_writes;
  int  gain_settings;
  bit  sender_burst;
  bit  long_hold_done;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // One line per mismatch, and a running count.
  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    error_count++;
  endtask

  // Runs one step of the selected loop and returns the drive value it should produce.
  function automatic drive_t predict_drive(logic axis, angle_t meas, angle_t targ);
    longint err, sum, derr, acc, drv, ilim, olim;
    int     ax;
    ax   = (axis == AXIS_UPPER) ? 1 : 0;
    ilim = (axis == AXIS_UPPER) ? UPPER_ISUM_LIM : LOWER_ISUM_LIM;
    olim = (axis == AXIS_UPPER) ? UPPER_DRV_LIM : LOWER_DRV_LIM;
    err  = longint'(meas) - longint'(targ);
    sum  = longint'(integ_acc[ax]) + err;
    if (sum > ilim) sum = ilim;
    if (sum < -ilim) sum = -ilim;
    integ_acc[ax] = isum_t'(sum);
    derr = err - longint'(prev_error[ax]);
    prev_error[ax] = err_t'(err);
    acc  = longint'(kp_gain[ax]) * err + longint'(ki_gain[ax]) * sum
         + longint'(kd_gain[ax]) * derr;
    // Division truncates toward zero, as the block's shift does.
    drv  = acc / 256;
    if (drv > olim) drv = olim;
    if (drv < -olim) drv = -olim;
    return drive_t'(drv);
  endfunction

  // Gaps between input items: mostly none, some short, a few long.
  function automatic int pick_gap();
    int r;
    if (sender_burst) return 0;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Gains: extremes now and then, often small values so outputs are not all saturated.
  function automatic gain_t pick_gain();
    int r;
    r = $urandom_range(0, 7);
    case (r)
      0: return GAIN_MAX;
      1: return GAIN_MIN;
      2: return 16'sd0;
      6, 7: return gain_t'($urandom);
      default: return gain_t'(int'($urandom_range(0, 1024)) - 512);
    endcase
  endfunction

  // Offers one item at a falling edge, waits for the transfer, then idles for a random gap, which may be none.
  task automatic send_item(logic axis, angle_t meas, angle_t targ, bit known, drive_t typed);
    drive_t pred;
    int     gap;
    in_chan.valid          = 1'b1;
    in_chan.axis_select    = axis;
    in_chan.measured_angle = meas;
    in_chan.target_angle   = targ;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    pred = predict_drive(axis, meas, targ);
    drive_expected_q.push_back(known ? typed : pred);
    items_sent++;
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_chan.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Writes one register through the configuration channel; the block must be idle.
  task automatic write_gain(cfg_idx_t idx, gain_t data);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data  = data;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    case (idx)
      REG_LOWER_PROP:  kp_gain[0] = data;
      REG_LOWER_INTEG: ki_gain[0] = data;
      REG_LOWER_DERIV: kd_gain[0] = data;
      REG_UPPER_PROP:  kp_gain[1] = data;
      REG_UPPER_INTEG: ki_gain[1] = data;
      REG_UPPER_DERIV: kd_gain[1] = data;
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  // Stops offering items until every expected drive value has come back.
  task automatic wait_results_drained();
    in_chan.valid = 1'b0;
    while (drive_expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_SLACK) @(negedge clk);
  endtask

  // Stimulus: reset, the directed table, then random phases with fresh gains.
  initial begin
    dir_row_t row;
    logic     axis;
    angle_t   meas;
    angle_t   targ;
    int       style;
    int       dir_items;
    error_count = 0;
    items_sent = 0;
    results_checked = 0;
    cfg_writes = 0;
    gain_settings = 1;
    sender_burst = 1'b0;
    kp_gain    = '{PROP_GAIN_RST, PROP_GAIN_RST};
    ki_gain    = '{ZERO_GAIN, ZERO_GAIN};
    kd_gain    = '{ZERO_GAIN, ZERO_GAIN};
    integ_acc  = '{'0, '0};
    prev_error = '{'0, '0};
    rst_n                  = 1'b0;
    in_chan.valid          = 1'b0;
    in_chan.axis_select    = AXIS_LOWER;
    in_chan.measured_angle = '0;
    in_chan.target_angle   = '0;
    cfg_bus.valid          = 1'b0;
    cfg_bus.index          = REG_LOWER_PROP;
    cfg_bus.data           = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table; a register row first lets the pipeline empty.
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = DIR_TAB[i];
      if (row.is_cfg) begin
        wait_results_drained();
        write_gain(row.idx, row.data);
        gain_settings++;
      end else begin
        send_item(row.axis, row.meas, row.targ, row.has_exp, row.exp_drive);
      end
    end
    dir_items = items_sent;

    // Random phases: each starts idle with a new gain set; some run without gaps.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_results_drained();
      for (int r = 0; r <= int'(REG_UPPER_DERIV); r++) write_gain(cfg_idx_t'(r), pick_gain());
      if ($urandom_range(0, 2) == 0)
        write_gain($urandom_range(0, 1) ? IDX_SPARE_A : IDX_SPARE_B, gain_t'($urandom));
      gain_settings++;
      sender_burst = (ph % 3 == 1);
      for (int k = 0; k < ITEMS_PER_PH; k++) begin
        axis  = logic'($urandom_range(0, 1));
        style = $urandom_range(0, 9);
        if (style < 3) begin
          meas = angle_t'($urandom);
          targ = angle_t'($urandom);
        end else if (style < 8) begin
          // Tracking: the measurement sits close to the target.
          targ = angle_t'($urandom);
          meas = angle_t'(int'(targ) + int'($urandom_range(0, 400)) - 200);
        end else begin
          meas = ANGLE_CORNERS[$urandom_range(0, 3)];
          targ = ANGLE_CORNERS[$urandom_range(0, 3)];
        end
        send_item(axis, meas, targ, 1'b0, '0);
      end
    end

    wait_results_drained();
    repeat (DRAIN_SLACK) @(negedge clk);
    $display("Summary: %0d input transfers (%0d directed), %0d drive values checked.",
             items_sent, dir_items, results_checked);
    $display("Summary: %0d register writes over %0d gain settings, %0d mismatches.",
             cfg_writes, gain_settings, error_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Result side: random ready with one long hold-off once the run is under way.
  initial begin
    int run_len;
    int r;
    long_hold_done = 1'b0;
    out_chan.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (!long_hold_done && results_checked >= HOLD_AFTER) begin
        out_chan.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold_done = 1'b1;
      end else begin
        run_len = $urandom_range(1, 40);
        out_chan.ready = 1'b1;
        repeat (run_len) @(negedge clk);
        r = $urandom_range(0, 19);
        if (r >= 12) begin
          out_chan.ready = 1'b0;
          repeat ((r < 18) ? $urandom_range(1, 4) : $urandom_range(15, 60)) @(negedge clk);
        end
      end
    end
  end

  // Checks each result transfer against the oldest expected drive value.
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (drive_expected_q.size() == 0) begin
        report_mismatch($sformatf("drive_value %0d with no item outstanding",
                                  out_chan.drive_value));
      end else begin
        if (out_chan.drive_value !== drive_expected_q[0])
          report_mismatch($sformatf("drive_value got %0d expected %0d",
                                    out_chan.drive_value, drive_expected_q[0]));
        void'(drive_expected_q.pop_front());
      end
      results_checked++;
    end
  end

  // Watchdog: ends the run if no transfer happens on any channel for too long.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
                 quiet, drive_expected_q.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/tapc_pkg.sv
rtl/core/tapc_if.sv
rtl/core/two_axis_pid_with_clamps.sv
tb/tb_two_axis_pid_with_clamps.sv
